// ===== rtl/grts_pkg.sv =====
// grts_pkg: types, constants and character-class helpers for the group
// reference token scanner. No dependencies.
package grts_pkg;

    localparam int unsigned TokenLen    = 6;
    localparam int unsigned WindowDepth = 7;
    localparam int unsigned RefWidth    = 8 * TokenLen;
    localparam logic [7:0]  DashCode    = 8'h2D;

    // Actions carried by an input word
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // One accepted input word as seen by the scan core
    typedef struct packed {
        logic       take;
        logic       action;
        logic [7:0] char_code;
    } t_scan_in;

    // Result of the end-of-string word
    typedef struct packed {
        logic                found;
        logic [RefWidth-1:0] ref_text;
    } t_scan_res;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || is_digit(c);
    endfunction

    // Lower-case letters drop bit 5; everything else passes
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? (c & 8'hDF) : c;
    endfunction

endpackage

// ===== rtl/grts_if.sv =====
// grts_if: valid/ready channel interfaces for the token scanner.
// Depends on nothing.
interface grts_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface grts_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [47:0] ref_text;

    modport source (output valid, output found, output ref_text, input ready);
    modport sink   (input valid, input found, input ref_text, output ready);
endinterface

// ===== rtl/grts_scan.sv =====
// grts_scan: seven-character window, match check and first-match capture.
// Depends on grts_pkg.
module grts_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grts_pkg::t_scan_in  i_step,
    output grts_pkg::t_scan_res o_res
);
    import grts_pkg::*;

    logic [7:0]          r_win [WindowDepth];
    logic [2:0]          r_seen;
    logic                r_latched;
    logic [RefWidth-1:0] r_captured;

    logic                right_ok;
    logic                left_ok;
    logic                pattern_ok;
    logic                hit;
    logic [RefWidth-1:0] packed_ref;

    // Boundary check on entry 6 and the incoming word, pattern check on entries 5..0
    always_comb begin
        right_ok   = (i_step.action == ACT_END) || !is_alnum(i_step.char_code);
        left_ok    = (r_seen == 3'(TokenLen)) || !is_alnum(r_win[6]);
        pattern_ok = is_letter(r_win[5]) && is_letter(r_win[4]) &&
                     (r_win[3] == DashCode) && is_digit(r_win[2]) &&
                     is_digit(r_win[1]) && is_digit(r_win[0]);
        hit        = !r_latched && (r_seen >= 3'(TokenLen)) && right_ok &&
                     left_ok && pattern_ok;
        packed_ref = {to_upper(r_win[5]), to_upper(r_win[4]), to_upper(r_win[3]),
                      to_upper(r_win[2]), to_upper(r_win[1]), to_upper(r_win[0])};
    end

    // Result for an end word (the top only registers it then)
    always_comb begin
        o_res.found = r_latched || hit;
        if (r_latched) begin
            o_res.ref_text = r_captured;
        end else if (hit) begin
            o_res.ref_text = packed_ref;
        end else begin
            o_res.ref_text = '0;
        end
    end

    // Window shift, count and capture; an end word clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.take && i_step.action == ACT_END)) begin
            for (int k = 0; k < WindowDepth; k++) begin
                r_win[k] <= '0;
            end
            r_seen     <= '0;
            r_latched  <= 1'b0;
            r_captured <= '0;
        end else if (i_step.take) begin
            for (int k = WindowDepth - 1; k > 0; k--) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0] <= i_step.char_code;
            if (r_seen < 3'(WindowDepth)) begin
                r_seen <= r_seen + 3'd1;
            end
            if (hit) begin
                r_latched  <= 1'b1;
                r_captured <= packed_ref;
            end
        end
    end

endmodule

// ===== rtl/group_ref_token_scanner_unit.sv =====
// group_ref_token_scanner_unit: top level of the token scanner.
// Depends on grts_pkg, grts_if (grts_in_if, grts_out_if) and grts_scan.
//
// Usage: feed a string on i_in one character word per cycle (action = 0),
// then one end word (action = 1). Only the end word yields a result word on
// o_out: found and the six token characters, letters upper-cased, first
// character in bits 47..40, zero when nothing matched. The scanner then
// clears its window for the next string.
// Throughput: one input word per cycle while i_in.ready is high, with the window
// update and match check combinational between the state registers and the result register.
// Latency: the result word is valid in the cycle after the end word is taken.
// The result sits in an output register; i_in.ready is low only while that
// register holds a word that the receiver has not yet taken, so a stalled
// receiver holds the scanner after one pending result.
// Reset (synchronous, active low) clears the window, the match latch and the
// output valid.
module group_ref_token_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grts_in_if.sink     i_in,
    grts_out_if.source  o_out
);
    import grts_pkg::*;

    t_scan_in  step;
    t_scan_res res;

    logic                r_out_valid;
    logic                r_found;
    logic [RefWidth-1:0] r_ref_text;
    logic                load_out;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign step.take   = i_in.valid && i_in.ready;
    assign step.action = i_in.action;
    assign step.char_code = i_in.char_code;
    assign load_out    = step.take && (i_in.action == ACT_END);

    grts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_found    <= res.found;
            r_ref_text <= res.ref_text;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_found;
    assign o_out.ref_text = r_ref_text;

`ifndef NO_ASSERTIONS
    // A new result only follows an accepted end word
    a_rise_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(step.take && i_in.action == ACT_END))
        else $error("result word without an end word");

    // No match means an all-zero token field
    a_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.ref_text == '0))
        else $error("ref_text nonzero without a match");

    // A match carries the dash in the third character
    a_dash_in_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (o_out.ref_text[31:24] == DashCode))
        else $error("matched token lacks the dash");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out.valid)
        else $error("result valid after reset");
`endif

endmodule
